/* rtl/rmq_pkg.sv */
// Shared constants, codes and saturation helper for the rotation-to-quaternion core.
package rmq_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int ELEM_W = 18;
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 72;

   typedef logic [1:0] mode_type;

   localparam mode_type MODE_X = 2'd0;
   localparam mode_type MODE_Y = 2'd1;
   localparam mode_type MODE_Z = 2'd2;
   localparam mode_type MODE_W = 2'd3;

   localparam logic [63:0] SAT_POS_MAG = 64'd131071;
   localparam logic [63:0] SAT_NEG_MAG = 64'd131072;

   // Turns a sign and a magnitude into a saturated 18-bit two's complement value.
   function automatic logic [ELEM_W-1:0] sat_q(input logic neg, input logic [63:0] mag);
      logic [ELEM_W-1:0] res;
      if (!neg) begin
         res = (mag > SAT_POS_MAG) ? 18'h1FFFF : mag[ELEM_W-1:0];
      end else begin
         res = (mag > SAT_NEG_MAG) ? 18'h20000 : 18'(18'd0 - mag[ELEM_W-1:0]);
      end
      return res;
   endfunction

endpackage

/* rtl/rotation_matrix_to_quaternion_core.sv */
// Pipelined rotation matrix to quaternion conversion (Shepperd's method).
// The input register is followed by SW = (RW + FRAC_BITS + 1) / 2 square-root
// stages, QW = 19 + FRAC_BITS divider stages and the output register.
// One beat is accepted every cycle unless a result waits; then the whole pipeline holds.
// Reset is synchronous and active high and clears the valid bits only.
module rotation_matrix_to_quaternion_core #(
   parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // m00, m01, m02, m10, m11, m12, m20, m21, m22 (18 bits each), 6 zero bits.
   input  logic [rmq_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // quat_w, quat_x, quat_y, quat_z (18 bits each).
   output logic [rmq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // degenerate.
   output logic                             rsp_tuser
);
   import rmq_pkg::*;

   localparam int RW = ((FRAC_BITS > 20) ? FRAC_BITS : 20) + 3;
   localparam int SW = (RW + FRAC_BITS + 1) / 2;
   localparam int NW = 2 * SW;
   localparam int RMW = SW + 3;
   localparam int DW = SW + 2;
   localparam int QW = 19 + FRAC_BITS;

   logic en;

   // Input stage.
   logic signed [ELEM_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
   logic signed [19:0]       trace;
   logic signed [RW-1:0]     rad_in, one_w;
   mode_type                 mode_in;
   logic signed [18:0]       d_in [0:2];
   logic [QW-1:0]            num_in [0:2];
   logic [2:0]               neg_in;
   logic [NW-1:0]            sqn_in;

   // Square-root pipeline.
   logic           sq_v_ff    [0:SW];
   logic [RMW-1:0] sq_rem_ff  [0:SW];
   logic [SW-1:0]  sq_root_ff [0:SW];
   logic [NW-1:0]  sq_num_ff  [0:SW];
   mode_type       sq_mode_ff [0:SW];
   logic           sq_deg_ff  [0:SW];
   logic [2:0]     sq_neg_ff  [0:SW];
   logic [QW-1:0]  sq_dn_ff   [0:SW][0:2];

   // Divider pipeline.
   logic          dv_v_ff    [1:QW];
   logic [DW-1:0] dv_rem_ff  [1:QW][0:2];
   logic [QW-1:0] dv_num_ff  [1:QW][0:2];
   logic [SW:0]   dv_div_ff  [1:QW];
   logic [SW-1:0] dv_half_ff [1:QW];
   mode_type      dv_mode_ff [1:QW];
   logic          dv_deg_ff  [1:QW];
   logic [2:0]    dv_neg_ff  [1:QW];

   // Output register.
   logic                  out_v_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;
   logic                  out_deg_ff;
   logic [RSP_DATA_W-1:0] out_data_in;

   assign en         = !out_v_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_deg_ff;

   always_comb begin
      m00   = req_tdata[0*ELEM_W +: ELEM_W];
      m01   = req_tdata[1*ELEM_W +: ELEM_W];
      m02   = req_tdata[2*ELEM_W +: ELEM_W];
      m10   = req_tdata[3*ELEM_W +: ELEM_W];
      m11   = req_tdata[4*ELEM_W +: ELEM_W];
      m12   = req_tdata[5*ELEM_W +: ELEM_W];
      m20   = req_tdata[6*ELEM_W +: ELEM_W];
      m21   = req_tdata[7*ELEM_W +: ELEM_W];
      m22   = req_tdata[8*ELEM_W +: ELEM_W];
      one_w = RW'(1) <<< FRAC_BITS;
      trace = 20'(m00) + 20'(m11) + 20'(m22);
      if (!trace[19]) begin
         mode_in = MODE_W;
      end else if (m22 > ((m11 > m00) ? m11 : m00)) begin
         mode_in = MODE_Z;
      end else if (m11 > m00) begin
         mode_in = MODE_Y;
      end else begin
         mode_in = MODE_X;
      end
      case (mode_in)
         MODE_X: begin
            rad_in  = one_w + RW'(m00) - RW'(m11) - RW'(m22);
            d_in[0] = 19'(m01) + 19'(m10);
            d_in[1] = 19'(m20) + 19'(m02);
            d_in[2] = 19'(m21) - 19'(m12);
         end
         MODE_Y: begin
            rad_in  = one_w + RW'(m11) - RW'(m22) - RW'(m00);
            d_in[0] = 19'(m12) + 19'(m21);
            d_in[1] = 19'(m01) + 19'(m10);
            d_in[2] = 19'(m02) - 19'(m20);
         end
         MODE_Z: begin
            rad_in  = one_w + RW'(m22) - RW'(m00) - RW'(m11);
            d_in[0] = 19'(m20) + 19'(m02);
            d_in[1] = 19'(m12) + 19'(m21);
            d_in[2] = 19'(m10) - 19'(m01);
         end
         default: begin
            rad_in  = one_w + RW'(trace);
            d_in[0] = 19'(m21) - 19'(m12);
            d_in[1] = 19'(m02) - 19'(m20);
            d_in[2] = 19'(m10) - 19'(m01);
         end
      endcase
      for (int k = 0; k < 3; k++) begin
         neg_in[k] = d_in[k][18];
         num_in[k] = QW'(d_in[k][18] ? 19'(19'd0 - d_in[k]) : d_in[k]) << FRAC_BITS;
      end
      sqn_in = (rad_in > 0) ? (NW'($unsigned(rad_in)) << FRAC_BITS) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (en) begin
         sq_v_ff[0] <= req_tvalid;
      end
      if (en) begin
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_num_ff[0]  <= sqn_in;
         sq_mode_ff[0] <= mode_in;
         sq_deg_ff[0]  <= !(rad_in > 0);
         sq_neg_ff[0]  <= neg_in;
         for (int k = 0; k < 3; k++) begin
            sq_dn_ff[0][k] <= num_in[k];
         end
      end
   end

   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      logic [RMW-1:0] rem_sh_in, trial_in, rem_in;
      logic [SW-1:0]  root_in;
      logic           ge_in;
      always_comb begin
         rem_sh_in = {sq_rem_ff[i][RMW-3:0], sq_num_ff[i][NW-1 -: 2]};
         trial_in  = RMW'({sq_root_ff[i], 2'b01});
         ge_in     = rem_sh_in >= trial_in;
         rem_in    = ge_in ? rem_sh_in - trial_in : rem_sh_in;
         root_in   = {sq_root_ff[i][SW-2:0], ge_in};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[i+1] <= 1'b0;
         end else if (en) begin
            sq_v_ff[i+1] <= sq_v_ff[i];
         end
         if (en) begin
            sq_rem_ff[i+1]  <= rem_in;
            sq_root_ff[i+1] <= root_in;
            sq_num_ff[i+1]  <= {sq_num_ff[i][NW-3:0], 2'b00};
            sq_mode_ff[i+1] <= sq_mode_ff[i];
            sq_deg_ff[i+1]  <= sq_deg_ff[i];
            sq_neg_ff[i+1]  <= sq_neg_ff[i];
            for (int k = 0; k < 3; k++) begin
               sq_dn_ff[i+1][k] <= sq_dn_ff[i][k];
            end
         end
      end
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      logic          v_src;
      logic [DW-1:0] rem_src [0:2];
      logic [QW-1:0] num_src [0:2];
      logic [SW:0]   div_src;
      logic [SW-1:0] half_src;
      mode_type      mode_src;
      logic          deg_src;
      logic [2:0]    neg_src;
      logic [DW-1:0] rem_sh_in [0:2];
      logic [DW-1:0] rem_in    [0:2];
      logic [2:0]    ge_in;
      if (j == 0) begin : g_head
         always_comb begin
            v_src    = sq_v_ff[SW];
            div_src  = {sq_root_ff[SW], 1'b0};
            half_src = sq_root_ff[SW] >> 1;
            mode_src = sq_mode_ff[SW];
            deg_src  = sq_deg_ff[SW];
            neg_src  = sq_neg_ff[SW];
            for (int k = 0; k < 3; k++) begin
               rem_src[k] = '0;
               num_src[k] = sq_dn_ff[SW][k];
            end
         end
      end else begin : g_body
         always_comb begin
            v_src    = dv_v_ff[j];
            div_src  = dv_div_ff[j];
            half_src = dv_half_ff[j];
            mode_src = dv_mode_ff[j];
            deg_src  = dv_deg_ff[j];
            neg_src  = dv_neg_ff[j];
            for (int k = 0; k < 3; k++) begin
               rem_src[k] = dv_rem_ff[j][k];
               num_src[k] = dv_num_ff[j][k];
            end
         end
      end
      always_comb begin
         for (int k = 0; k < 3; k++) begin
            rem_sh_in[k] = {rem_src[k][DW-2:0], num_src[k][QW-1]};
            ge_in[k]     = rem_sh_in[k] >= DW'(div_src);
            rem_in[k]    = ge_in[k] ? rem_sh_in[k] - DW'(div_src) : rem_sh_in[k];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else if (en) begin
            dv_v_ff[j+1] <= v_src;
         end
         if (en) begin
            dv_div_ff[j+1]  <= div_src;
            dv_half_ff[j+1] <= half_src;
            dv_mode_ff[j+1] <= mode_src;
            dv_deg_ff[j+1]  <= deg_src;
            dv_neg_ff[j+1]  <= neg_src;
            for (int k = 0; k < 3; k++) begin
               dv_rem_ff[j+1][k] <= rem_in[k];
               dv_num_ff[j+1][k] <= {num_src[k][QW-2:0], ge_in[k]};
            end
         end
      end
   end

   always_comb begin
      logic [ELEM_W-1:0] half_q, q0, q1, q2;
      logic [ELEM_W-1:0] qw, qx, qy, qz;
      half_q = sat_q(1'b0, 64'(dv_half_ff[QW]));
      q0     = sat_q(dv_neg_ff[QW][0], 64'(dv_num_ff[QW][0]));
      q1     = sat_q(dv_neg_ff[QW][1], 64'(dv_num_ff[QW][1]));
      q2     = sat_q(dv_neg_ff[QW][2], 64'(dv_num_ff[QW][2]));
      unique case (dv_mode_ff[QW])
         MODE_X: begin
            qx = half_q; qy = q0; qz = q1; qw = q2;
         end
         MODE_Y: begin
            qy = half_q; qz = q0; qx = q1; qw = q2;
         end
         MODE_Z: begin
            qz = half_q; qx = q0; qy = q1; qw = q2;
         end
         default: begin
            qw = half_q; qx = q0; qy = q1; qz = q2;
         end
      endcase
      out_data_in = dv_deg_ff[QW] ? '0 : {qz, qy, qx, qw};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= dv_v_ff[QW];
      end
      if (en) begin
         out_data_ff <= out_data_in;
         out_deg_ff  <= dv_deg_ff[QW];
      end
   end

endmodule
